@@ rtl/tfsig_pkg.sv @@
// Shared types and constants for the track format sector ID generator.
// No dependencies.
`default_nettype none

package tfsig_pkg;

  localparam int unsigned TRACK_W = 8;
  localparam int unsigned SPT_W   = 6;
  localparam int unsigned HC_W    = 2;
  localparam int unsigned SIZE_W  = 3;
  localparam int unsigned CFG_W   = 6;

  localparam logic [SIZE_W-1:0] SIZE_CODE_512 = 3'd2;

  localparam logic REG_SPT        = 1'b0;
  localparam logic REG_HEAD_COUNT = 1'b1;

  typedef struct packed {
    logic [SPT_W-1:0] spt;
    logic [HC_W-1:0]  head_count;
  } cfg_t;

  typedef struct packed {
    logic [SPT_W-1:0] rec;
    logic             head;
    logic             track_odd;
    logic [SPT_W-1:0] spt;
  } calc_req_t;

endpackage

`default_nettype wire

@@ rtl/tfsig_sector_calc.sv @@
// Sector number unit: interleave, head skew and track skew for one record.
// Depends on tfsig_pkg.
`default_nettype none

module tfsig_sector_calc (
  input  var tfsig_pkg::calc_req_t       req,
  output logic [tfsig_pkg::SPT_W-1:0]    sector
);

  logic [tfsig_pkg::SPT_W:0] split;
  logic [tfsig_pkg::SPT_W:0] half;
  logic [tfsig_pkg::SPT_W:0] spt_x;
  logic [tfsig_pkg::SPT_W:0] id_il;
  logic [tfsig_pkg::SPT_W:0] id_hs;
  logic [tfsig_pkg::SPT_W:0] id_ts;

  always_comb begin
    spt_x = {1'b0, req.spt};
    split = (spt_x + 7'd1) >> 1;
    half  = spt_x >> 1;
    id_il = {2'b00, req.rec[tfsig_pkg::SPT_W-1:1]} + 7'd1;
    if (req.rec[0]) begin
      id_il = id_il + split;
    end
    id_hs = id_il;
    if (req.head) begin
      if (id_il <= 7'd2) begin
        id_hs = id_il + spt_x - 7'd2;
      end else begin
        id_hs = id_il - 7'd2;
      end
    end
    id_ts = id_hs;
    if (req.track_odd) begin
      if (id_hs <= half) begin
        id_ts = id_hs + spt_x - half;
      end else begin
        id_ts = id_hs - half;
      end
    end
    sector = id_ts[tfsig_pkg::SPT_W-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/tfsig_seq.sv @@
// Record sequencer: walks heads and records, drives the sector unit and
// registers each ID record. Depends on tfsig_pkg and tfsig_sector_calc.
`default_nettype none

module tfsig_seq #(
  parameter int unsigned SPT_SMALL = 18,
  parameter int unsigned SPT_LARGE = 21
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  var tfsig_pkg::cfg_t             cfg,
  input  logic                            start,
  input  logic [tfsig_pkg::TRACK_W-1:0]   track_in,
  output logic                            busy,
  output logic                            out_valid,
  output logic [tfsig_pkg::TRACK_W-1:0]   out_id_track,
  output logic                            out_id_head,
  output logic [tfsig_pkg::SPT_W-1:0]     out_id_sector,
  output logic [tfsig_pkg::SIZE_W-1:0]    out_id_size_code,
  output logic                            out_head_done,
  output logic                            out_bad_geometry,
  output logic                            out_last
);

  logic                          busy_r, busy_nxt;
  logic                          bad_r, bad_nxt;
  logic [tfsig_pkg::SPT_W-1:0]   rec_r, rec_nxt;
  logic                          head_r, head_nxt;
  logic [tfsig_pkg::TRACK_W-1:0] track_r, track_nxt;
  logic                          valid_r, valid_nxt;

  logic [tfsig_pkg::TRACK_W-1:0] o_track_r, o_track_nxt;
  logic                          o_head_r, o_head_nxt;
  logic [tfsig_pkg::SPT_W-1:0]   o_sector_r, o_sector_nxt;
  logic [tfsig_pkg::SIZE_W-1:0]  o_size_r, o_size_nxt;
  logic                          o_hdone_r, o_hdone_nxt;
  logic                          o_bad_r, o_bad_nxt;
  logic                          o_last_r, o_last_nxt;

  logic                          accept;
  logic                          geom_bad;
  logic                          two_heads;
  logic                          end_head;
  logic                          last_rec;
  tfsig_pkg::calc_req_t          req;
  logic [tfsig_pkg::SPT_W-1:0]   sector;

  assign accept    = start && !busy_r;
  assign geom_bad  = (cfg.spt != tfsig_pkg::SPT_W'(SPT_SMALL)) &&
                     (cfg.spt != tfsig_pkg::SPT_W'(SPT_LARGE));
  assign two_heads = cfg.head_count[1];
  assign end_head  = (rec_r == cfg.spt - 6'd1);
  assign last_rec  = end_head && (head_r || !two_heads);

  always_comb begin
    req.rec       = rec_r;
    req.head      = head_r;
    req.track_odd = track_r[0];
    req.spt       = cfg.spt;
  end

  tfsig_sector_calc u_calc (
    .req    (req),
    .sector (sector)
  );

  always_comb begin
    busy_nxt     = busy_r;
    bad_nxt      = bad_r;
    rec_nxt      = rec_r;
    head_nxt     = head_r;
    track_nxt    = track_r;
    valid_nxt    = busy_r;
    o_track_nxt  = o_track_r;
    o_head_nxt   = o_head_r;
    o_sector_nxt = o_sector_r;
    o_size_nxt   = o_size_r;
    o_hdone_nxt  = o_hdone_r;
    o_bad_nxt    = o_bad_r;
    o_last_nxt   = o_last_r;
    if (accept) begin
      busy_nxt  = 1'b1;
      bad_nxt   = geom_bad;
      rec_nxt   = '0;
      head_nxt  = 1'b0;
      track_nxt = track_in;
    end else if (busy_r) begin
      o_track_nxt = track_r;
      if (bad_r) begin
        o_head_nxt   = 1'b0;
        o_sector_nxt = '0;
        o_size_nxt   = '0;
        o_hdone_nxt  = 1'b0;
        o_bad_nxt    = 1'b1;
        o_last_nxt   = 1'b1;
        busy_nxt     = 1'b0;
      end else begin
        o_head_nxt   = head_r;
        o_sector_nxt = sector;
        o_size_nxt   = tfsig_pkg::SIZE_CODE_512;
        o_hdone_nxt  = end_head;
        o_bad_nxt    = 1'b0;
        o_last_nxt   = last_rec;
        if (last_rec) begin
          busy_nxt = 1'b0;
          rec_nxt  = '0;
          head_nxt = 1'b0;
        end else if (end_head) begin
          rec_nxt  = '0;
          head_nxt = 1'b1;
        end else begin
          rec_nxt = rec_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      rec_r   <= '0;
      head_r  <= 1'b0;
      bad_r   <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
      rec_r   <= rec_nxt;
      head_r  <= head_nxt;
      bad_r   <= bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    track_r    <= track_nxt;
    o_track_r  <= o_track_nxt;
    o_head_r   <= o_head_nxt;
    o_sector_r <= o_sector_nxt;
    o_size_r   <= o_size_nxt;
    o_hdone_r  <= o_hdone_nxt;
    o_bad_r    <= o_bad_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign busy             = busy_r;
  assign out_valid        = valid_r;
  assign out_id_track     = o_track_r;
  assign out_id_head      = o_head_r;
  assign out_id_sector    = o_sector_r;
  assign out_id_size_code = o_size_r;
  assign out_head_done    = o_hdone_r;
  assign out_bad_geometry = o_bad_r;
  assign out_last         = o_last_r;

endmodule

`default_nettype wire

@@ rtl/track_format_sector_id_generator.sv @@
// Track format sector ID generator top level: configuration registers and
// record sequencer. Depends on tfsig_pkg, tfsig_seq, tfsig_sector_calc.
//
// A request on start (taken while busy is low) names a track; the block then
// emits one ID record per cycle on the out_ ports, marked by out_valid, first
// all records of head 0 and then, with two heads, those of head 1. Busy stays
// high for heads * sectors_per_track records (at most 42 with the default
// geometries), one record per cycle from the single sector-number unit, and
// the next request can be taken at the edge after busy falls. An unsupported
// geometry gives one error record and keeps busy high for one cycle. The
// first record is registered at the clock edge after the one that takes the
// request. Records cannot be stalled: the receiver must take each one in the
// cycle it is shown. Write configuration only while busy is low.
`default_nettype none

module track_format_sector_id_generator #(
  parameter int unsigned SPT_SMALL = 18,
  parameter int unsigned SPT_LARGE = 21
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [tfsig_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                            start,
  output logic                            busy,
  input  logic [tfsig_pkg::TRACK_W-1:0]   in_track_number,
  output logic                            out_valid,
  output logic [tfsig_pkg::TRACK_W-1:0]   out_id_track,
  output logic                            out_id_head,
  output logic [tfsig_pkg::SPT_W-1:0]     out_id_sector,
  output logic [tfsig_pkg::SIZE_W-1:0]    out_id_size_code,
  output logic                            out_head_done,
  output logic                            out_bad_geometry,
  output logic                            out_last
);

  tfsig_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tfsig_pkg::REG_SPT:        cfg_nxt.spt        = cfg_wdata;
        tfsig_pkg::REG_HEAD_COUNT: cfg_nxt.head_count = cfg_wdata[tfsig_pkg::HC_W-1:0];
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.spt        <= 6'd18;
      cfg_r.head_count <= 2'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tfsig_seq #(
    .SPT_SMALL (SPT_SMALL),
    .SPT_LARGE (SPT_LARGE)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .start            (start),
    .track_in         (in_track_number),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_id_track     (out_id_track),
    .out_id_head      (out_id_head),
    .out_id_sector    (out_id_sector),
    .out_id_size_code (out_id_size_code),
    .out_head_done    (out_head_done),
    .out_bad_geometry (out_bad_geometry),
    .out_last         (out_last)
  );

endmodule

`default_nettype wire

@@ rtl/tfsig_checker.sv @@
// Port-level checks for the track format sector ID generator, bound to the
// top level. Depends on tfsig_pkg.
`default_nettype none

module tfsig_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_valid,
  input logic [tfsig_pkg::SPT_W-1:0]     out_id_sector,
  input logic [tfsig_pkg::SIZE_W-1:0]    out_id_size_code,
  input logic                            out_bad_geometry,
  input logic                            out_last
);

  a_req_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_busy_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("run ended without a last record");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("still busy on last record");

  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_geometry |-> out_last && out_id_sector == '0)
    else $error("error record malformed");

  a_good_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_bad_geometry |->
      out_id_size_code == tfsig_pkg::SIZE_CODE_512 && out_id_sector != '0)
    else $error("ID record malformed");

endmodule

bind track_format_sector_id_generator tfsig_checker u_tfsig_checker (.*);

`default_nettype wire
